// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define RMSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define RMSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RMSP_ASSERT(lbl, clk, rstn, prop, msg)
`define RMSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/rmsp_pkg.sv
// ----------------------------------------------------------------------------
// RMSProp update package
// Shared widths, reset values, register and status codes, and link structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rmsp_pkg;

  localparam int unsigned FracBits     = 16;
  localparam int unsigned CacheDepth   = 4096;
  localparam int unsigned IdxW         = 12;
  localparam int unsigned DataW        = 32;
  localparam int unsigned DecayW       = 17;
  localparam int unsigned EpsW         = 16;
  localparam int unsigned BatchW       = 16;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned RootW        = (DataW + FracBits) / 2;
  localparam int unsigned DivW         = RootW + 1;
  localparam int unsigned OutFifoDepth = 32;

  localparam logic [DataW-1:0]  LrReset    = 32'd65;
  localparam logic [DecayW-1:0] DecayReset = 17'd58982;
  localparam logic [EpsW-1:0]   EpsReset   = 16'd1;
  localparam logic [BatchW-1:0] BatchReset = 16'd1;
  localparam logic [DecayW-1:0] DecayOne   = DecayW'(2 ** FracBits);

  typedef enum logic [CfgIdxW-1:0] {
    CfgLearningRate = 2'd0,
    CfgDecayRate    = 2'd1,
    CfgEpsilon      = 2'd2,
    CfgBatchSize    = 2'd3
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk      = 2'd0,
    StatusSat     = 2'd1,
    StatusDivZero = 2'd2
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] sq;
  } cache_req_t;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] cnew;
    logic             sat;
  } cache_rsp_t;

endpackage

`default_nettype wire

// File: src/rmsp_ifs.sv
// ----------------------------------------------------------------------------
// RMSProp channel interfaces
// Valid/ready channels for gradient items, update items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmsp_grad_if;
  logic                              valid;
  logic                              ready;
  logic [rmsp_pkg::IdxW-1:0]         weight_index;
  logic signed [rmsp_pkg::DataW-1:0] gradient;
  logic                              frozen;
  modport source (output valid, weight_index, gradient, frozen, input ready);
  modport sink   (input valid, weight_index, gradient, frozen, output ready);
endinterface

interface rmsp_upd_if;
  logic                              valid;
  logic                              ready;
  logic [rmsp_pkg::IdxW-1:0]         result_index;
  logic signed [rmsp_pkg::DataW-1:0] weight_delta;
  logic [rmsp_pkg::StatusW-1:0]      status;
  modport source (output valid, result_index, weight_delta, status, input ready);
  modport sink   (input valid, result_index, weight_delta, status, output ready);
endinterface

interface rmsp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rmsp_pkg::CfgIdxW-1:0] index;
  logic [rmsp_pkg::DataW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/rmsprop_weight_update.sv
// ----------------------------------------------------------------------------
// RMSProp weight update
// Streams gradient items through a cache read-modify-write and returns the
// saturated Q16.16 weight delta for each item that is not frozen.
// ----------------------------------------------------------------------------
//
//   port     dir  kind        moves
//   grad_i   in   valid/ready one gradient item (index, gradient, frozen)
//   upd_o    out  valid/ready one update item (index, delta, status)
//   cfg_i    in   valid/ready one register write (index, data), always ready
//
// One item per cycle while grad_i is ready; an item passes from acceptance to
// the result queue through: sign stage, 8 batch divider stages, square, cache read
// and update (2), 6 root stages, product, 8 quotient stages.
// After reset all CACHE_DEPTH cache entries are swept to zero, one entry a cycle,
// while grad_i is held not ready.
// Up to 32 items are in flight or queued; grad_i drops ready when that many
// results are owed, so a stalled upd_o backs up only after the queue fills.
// Frozen items are accepted and dropped at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rmsprop_weight_update #(
  parameter int unsigned CACHE_DEPTH = rmsp_pkg::CacheDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmsp_grad_if.sink  grad_i,
  rmsp_upd_if.source upd_o,
  rmsp_cfg_if.sink   cfg_i
);
  import rmsp_pkg::*;

  // Depth is a power of two; the cache slot is the low index bits.
  localparam int unsigned AddrW = $clog2(CACHE_DEPTH);
  localparam int unsigned CntW  = $clog2(OutFifoDepth + 1);

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            neg;
  } bdiv_tag_t;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic             neg;
    logic [DataW-1:0] mag;
    logic             sat;
  } stag_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            neg;
    logic            sat;
    logic            ovf;
    logic            zero;
  } qtag_t;

  typedef struct packed {
    logic [IdxW-1:0]    idx;
    logic [DataW-1:0]   delta;
    logic [StatusW-1:0] status;
  } result_t;

  // ---------------- configuration registers ----------------
  logic [DataW-1:0]  lr_q;
  logic [DecayW-1:0] decay_q;
  logic [EpsW-1:0]   eps_q;
  logic [BatchW-1:0] batch_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= LrReset;
      decay_q <= DecayReset;
      eps_q   <= EpsReset;
      batch_q <= BatchReset;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CfgLearningRate: lr_q    <= cfg_i.data;
        CfgDecayRate:    decay_q <= cfg_i.data[DecayW-1:0];
        CfgEpsilon:      eps_q   <= cfg_i.data[EpsW-1:0];
        CfgBatchSize:    batch_q <= cfg_i.data[BatchW-1:0];
        default: ;
      endcase
    end
  end

  // Batch size zero acts as one; decay saturates at one.
  logic [BatchW-1:0] batch_eff;
  logic [DecayW-1:0] decay_eff;
  logic [DecayW-1:0] omd;

  assign batch_eff = (batch_q == '0) ? BatchW'(1) : batch_q;
  assign decay_eff = (decay_q > DecayOne) ? DecayOne : decay_q;
  assign omd       = DecayOne - decay_eff;

  // ---------------- input acceptance and credits ----------------
  logic            cache_busy;
  logic [CntW-1:0] cnt_q;
  logic            in_ready;
  logic            acc_live;
  logic            pop;
  logic            v4;

  assign in_ready     = !cache_busy && (cnt_q < CntW'(OutFifoDepth));
  assign grad_i.ready = in_ready;
  assign acc_live     = grad_i.valid && in_ready && !grad_i.frozen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CntW'(acc_live) - CntW'(pop);
    end
  end

  // ---------------- stage 0: sign and magnitude ----------------
  logic             v0_q;
  logic [IdxW-1:0]  idx0_q;
  logic             neg0_q;
  logic [DataW-1:0] mag0_q;
  logic [DataW-1:0] g_raw;

  assign g_raw = unsigned'(grad_i.gradient);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= acc_live;
    end
  end

  always_ff @(posedge clk_i) begin
    idx0_q <= grad_i.weight_index;
    neg0_q <= g_raw[DataW-1];
    mag0_q <= g_raw[DataW-1] ? (DataW'(0) - g_raw) : g_raw;
  end

  // ---------------- gradient / batch size ----------------
  logic                         v1;
  logic [DataW-1:0]             q1;
  logic [$bits(bdiv_tag_t)-1:0] t1_raw;
  bdiv_tag_t                    t1;

  rmsp_div_pipe #(
    .NUM_W (DataW),
    .DEN_W (BatchW),
    .STEPS (4),
    .TAG_W ($bits(bdiv_tag_t))
  ) u_bdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .rem_i   ('0),
    .num_i   (mag0_q),
    .den_i   (batch_eff),
    .tag_i   (bdiv_tag_t'{idx: idx0_q, neg: neg0_q}),
    .valid_o (v1),
    .quot_o  (q1),
    .tag_o   (t1_raw)
  );

  assign t1 = bdiv_tag_t'(t1_raw);

  // ---------------- square ----------------
  logic               v2_q;
  logic [2*DataW-1:0] prod2_q;
  logic [IdxW-1:0]    idx2_q;
  logic               neg2_q;
  logic [DataW-1:0]   mag2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1;
    end
  end

  // A quotient of zero carries no sign.
  always_ff @(posedge clk_i) begin
    prod2_q <= (2*DataW)'(q1) * (2*DataW)'(q1);
    idx2_q  <= t1.idx;
    neg2_q  <= t1.neg && (q1 != '0);
    mag2_q  <= q1;
  end

  logic [2*DataW-1:0] sq_wide;
  logic               sq_sat;
  logic [DataW-1:0]   sq;

  assign sq_wide = prod2_q >> FracBits;
  assign sq_sat  = |sq_wide[2*DataW-1:DataW];
  assign sq      = sq_sat ? '1 : sq_wide[DataW-1:0];

  // ---------------- cache read-modify-write ----------------
  cache_rsp_t               crsp;
  logic [$bits(stag_t)-1:0] ctag_raw;
  stag_t                    ctag;

  rmsp_cache #(
    .DEPTH  (CACHE_DEPTH),
    .ADDR_W (AddrW),
    .TAG_W  ($bits(stag_t))
  ) u_cache (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cache_req_t'{valid: v2_q, sq: sq}),
    .slot_i  (AddrW'(idx2_q)),
    .decay_i (decay_eff),
    .omd_i   (omd),
    .tag_i   (stag_t'{idx: idx2_q, neg: neg2_q, mag: mag2_q, sat: sq_sat}),
    .rsp_o   (crsp),
    .tag_o   (ctag_raw),
    .busy_o  (cache_busy)
  );

  assign ctag = stag_t'(ctag_raw);

  // ---------------- square root of the new cache value ----------------
  logic                     v3;
  logic [RootW-1:0]         root3;
  logic [$bits(stag_t)-1:0] rtag_raw;
  stag_t                    rtag;

  rmsp_isqrt_pipe #(
    .ROOT_W (RootW),
    .STEPS  (4),
    .TAG_W  ($bits(stag_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (crsp.valid),
    .rad_i   ({crsp.cnew, {FracBits{1'b0}}}),
    .tag_i   (stag_t'{idx: ctag.idx, neg: ctag.neg, mag: ctag.mag,
                      sat: ctag.sat || crsp.sat}),
    .valid_o (v3),
    .root_o  (root3),
    .tag_o   (rtag_raw)
  );

  assign rtag = stag_t'(rtag_raw);

  // ---------------- numerator and divisor ----------------
  logic               vp_q;
  logic [2*DataW-1:0] prodp_q;
  logic [DivW-1:0]    divp_q;
  logic [IdxW-1:0]    idxp_q;
  logic               negp_q;
  logic               satp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    prodp_q <= (2*DataW)'(rtag.mag) * (2*DataW)'(lr_q);
    divp_q  <= DivW'(root3) + DivW'(eps_q);
    idxp_q  <= rtag.idx;
    negp_q  <= rtag.neg;
    satp_q  <= rtag.sat;
  end

  // A high half at or above the divisor means the quotient needs over 32 bits.
  logic p_ovf;
  logic p_zero;

  assign p_ovf  = prodp_q[2*DataW-1:DataW] >= DataW'(divp_q);
  assign p_zero = (divp_q == '0);

  // ---------------- quotient ----------------
  logic                     [DataW-1:0] q4;
  logic [$bits(qtag_t)-1:0] qtag_raw;
  qtag_t                    qtag;

  rmsp_div_pipe #(
    .NUM_W (DataW),
    .DEN_W (DivW),
    .STEPS (4),
    .TAG_W ($bits(qtag_t))
  ) u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp_q),
    .rem_i   (DivW'(prodp_q[2*DataW-1:DataW])),
    .num_i   (prodp_q[DataW-1:0]),
    .den_i   (divp_q),
    .tag_i   (qtag_t'{idx: idxp_q, neg: negp_q, sat: satp_q, ovf: p_ovf,
                      zero: p_zero}),
    .valid_o (v4),
    .quot_o  (q4),
    .tag_o   (qtag_raw)
  );

  assign qtag = qtag_t'(qtag_raw);

  // ---------------- sign, saturation and status ----------------
  logic [DataW-1:0] delta;
  status_e          status;

  always_comb begin
    logic sat;
    sat    = qtag.sat;
    delta  = '0;
    status = StatusOk;
    if (qtag.zero) begin
      status = StatusDivZero;
    end else begin
      if (qtag.neg) begin
        if (qtag.ovf || (q4 > 32'h7FFF_FFFF)) begin
          delta = 32'h7FFF_FFFF;
          sat   = 1'b1;
        end else begin
          delta = q4;
        end
      end else begin
        if (qtag.ovf || (q4 > 32'h8000_0000)) begin
          delta = 32'h8000_0000;
          sat   = 1'b1;
        end else begin
          delta = DataW'(0) - q4;
        end
      end
      status = sat ? StatusSat : StatusOk;
    end
  end

  // ---------------- result queue ----------------
  result_t res_out;

  rmsp_out_fifo #(
    .DEPTH (OutFifoDepth),
    .W     ($bits(result_t))
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v4),
    .din_i   (result_t'{idx: qtag.idx, delta: delta, status: status}),
    .pop_i   (pop),
    .valid_o (upd_o.valid),
    .dout_o  (res_out)
  );

  assign pop                = upd_o.valid && upd_o.ready;
  assign upd_o.result_index = res_out.idx;
  assign upd_o.weight_delta = signed'(res_out.delta);
  assign upd_o.status       = res_out.status;

  // ---------------- checks ----------------
  `RMSP_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(OutFifoDepth), "credit overrun")
  `RMSP_ASSERT(a_no_accept_clear, clk_i, rst_ni, grad_i.ready |-> !cache_busy, "ready in clear")
  `RMSP_ASSERT(a_push_owed, clk_i, rst_ni, v4 |-> (cnt_q != '0), "push without credit")
  `RMSP_ASSERT(a_clear_idle, clk_i, rst_ni, cache_busy |-> !v2_q, "cache request during clear")

endmodule

`default_nettype wire

// File: src/rmsp_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// STEPS quotient bits per stage; a tag travels alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsp_div_pipe #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16,
  parameter int unsigned STEPS = 4,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [TAG_W-1:0] tag_o
);
  import rmsp_pkg::*;

  localparam int unsigned Stages = NUM_W / STEPS;

  logic             vld_q [Stages];
  logic [DEN_W-1:0] rem_q [Stages];
  logic [NUM_W-1:0] nq_q  [Stages];
  logic [DEN_W-1:0] den_q [Stages];
  logic [TAG_W-1:0] tag_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic             src_v;
    logic [DEN_W-1:0] src_rem;
    logic [NUM_W-1:0] src_nq;
    logic [DEN_W-1:0] src_den;
    logic [TAG_W-1:0] src_tag;
    logic [DEN_W-1:0] rem_d;
    logic [NUM_W-1:0] nq_d;

    if (s == 0) begin : g_first
      assign src_v   = valid_i;
      assign src_rem = rem_i;
      assign src_nq  = num_i;
      assign src_den = den_i;
      assign src_tag = tag_i;
    end else begin : g_next
      assign src_v   = vld_q[s-1];
      assign src_rem = rem_q[s-1];
      assign src_nq  = nq_q[s-1];
      assign src_den = den_q[s-1];
      assign src_tag = tag_q[s-1];
    end

    // Shift one numerator bit into the remainder, subtract where it fits.
    always_comb begin
      logic [DEN_W:0]   t;
      logic [DEN_W-1:0] r;
      logic [NUM_W-1:0] n;
      r = src_rem;
      n = src_nq;
      for (int k = 0; k < STEPS; k++) begin
        t = {r, n[NUM_W-1]};
        if (t >= {1'b0, src_den}) begin
          t = t - {1'b0, src_den};
          n = {n[NUM_W-2:0], 1'b1};
        end else begin
          n = {n[NUM_W-2:0], 1'b0};
        end
        r = t[DEN_W-1:0];
      end
      rem_d = r;
      nq_d  = n;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      nq_q[s]  <= nq_d;
      den_q[s] <= src_den;
      tag_q[s] <= src_tag;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign quot_o  = nq_q[Stages-1];
  assign tag_o   = tag_q[Stages-1];

endmodule

`default_nettype wire

// File: src/rmsp_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor root of a 2*ROOT_W bit radicand, STEPS root bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsp_isqrt_pipe #(
  parameter int unsigned ROOT_W = 24,
  parameter int unsigned STEPS  = 4,
  parameter int unsigned TAG_W  = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [TAG_W-1:0]      tag_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [TAG_W-1:0]      tag_o
);
  import rmsp_pkg::*;

  localparam int unsigned Stages = ROOT_W / STEPS;

  logic                vld_q  [Stages];
  logic [2*ROOT_W-1:0] rad_q  [Stages];
  logic [ROOT_W:0]     rem_q  [Stages];
  logic [ROOT_W-1:0]   root_q [Stages];
  logic [TAG_W-1:0]    tag_q  [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic                src_v;
    logic [2*ROOT_W-1:0] src_rad;
    logic [ROOT_W:0]     src_rem;
    logic [ROOT_W-1:0]   src_root;
    logic [TAG_W-1:0]    src_tag;
    logic [2*ROOT_W-1:0] rad_d;
    logic [ROOT_W:0]     rem_d;
    logic [ROOT_W-1:0]   root_d;

    if (s == 0) begin : g_first
      assign src_v    = valid_i;
      assign src_rad  = rad_i;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_tag  = tag_i;
    end else begin : g_next
      assign src_v    = vld_q[s-1];
      assign src_rad  = rad_q[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_root = root_q[s-1];
      assign src_tag  = tag_q[s-1];
    end

    // Bring down two radicand bits, try root*4+1, keep the root bit.
    always_comb begin
      logic [ROOT_W+2:0]   t;
      logic [ROOT_W+2:0]   tr;
      logic [ROOT_W:0]     r;
      logic [ROOT_W-1:0]   rt;
      logic [2*ROOT_W-1:0] rd;
      r  = src_rem;
      rt = src_root;
      rd = src_rad;
      for (int k = 0; k < STEPS; k++) begin
        t  = {r, rd[2*ROOT_W-1 -: 2]};
        tr = {1'b0, rt, 2'b01};
        if (t >= tr) begin
          t  = t - tr;
          rt = {rt[ROOT_W-2:0], 1'b1};
        end else begin
          rt = {rt[ROOT_W-2:0], 1'b0};
        end
        r  = t[ROOT_W:0];
        rd = {rd[2*ROOT_W-3:0], 2'b00};
      end
      rad_d  = rd;
      rem_d  = r;
      root_d = rt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_d;
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
      tag_q[s]  <= src_tag;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign root_o  = root_q[Stages-1];
  assign tag_o   = tag_q[Stages-1];

endmodule

`default_nettype wire

// File: src/rmsp_cache.sv
// ----------------------------------------------------------------------------
// Mean-square cache
// Cache memory with read-modify-write, write forwarding and a clear sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsp_cache #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned TAG_W  = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmsp_pkg::cache_req_t          req_i,
  input  logic [ADDR_W-1:0]             slot_i,
  input  logic [rmsp_pkg::DecayW-1:0]   decay_i,
  input  logic [rmsp_pkg::DecayW-1:0]   omd_i,
  input  logic [TAG_W-1:0]              tag_i,
  output rmsp_pkg::cache_rsp_t          rsp_o,
  output logic [TAG_W-1:0]              tag_o,
  output logic                          busy_o
);
  import rmsp_pkg::*;

  localparam int unsigned ProdW = DataW + DecayW;

  logic [DataW-1:0]  mem [DEPTH];
  logic              busy_q;
  logic [ADDR_W-1:0] clr_q;
  logic              rd_v_q;
  logic [ADDR_W-1:0] rd_slot_q;
  logic [DataW-1:0]  rd_sq_q;
  logic [TAG_W-1:0]  rd_tag_q;
  logic [DataW-1:0]  rdata_q;
  logic              fwd_q;
  logic [DataW-1:0]  fwd_data_q;
  logic              rsp_v_q;
  logic [DataW-1:0]  rsp_cnew_q;
  logic              rsp_sat_q;
  logic [TAG_W-1:0]  rsp_tag_q;

  logic [DataW-1:0]  c_old;
  logic [ProdW-1:0]  m_old;
  logic [ProdW-1:0]  m_new;
  logic [DataW+1:0]  sum;
  logic              sat;
  logic [DataW-1:0]  cnew;

  // Take the value just written when the previous item hit the same entry.
  assign c_old = fwd_q ? fwd_data_q : rdata_q;
  assign m_old = ProdW'(c_old) * ProdW'(decay_i);
  assign m_new = ProdW'(rd_sq_q) * ProdW'(omd_i);
  assign sum   = (DataW+2)'(m_old >> FracBits) + (DataW+2)'(m_new >> FracBits);
  assign sat   = |sum[DataW+1:DataW];
  assign cnew  = sat ? '1 : sum[DataW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      clr_q   <= '0;
      rd_v_q  <= 1'b0;
      fwd_q   <= 1'b0;
      rsp_v_q <= 1'b0;
    end else begin
      if (busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          busy_q <= 1'b0;
        end
      end
      rd_v_q  <= req_i.valid;
      fwd_q   <= req_i.valid && rd_v_q && (slot_i == rd_slot_q);
      rsp_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q  <= slot_i;
    rd_sq_q    <= req_i.sq;
    rd_tag_q   <= tag_i;
    fwd_data_q <= cnew;
    rsp_cnew_q <= cnew;
    rsp_sat_q  <= sat;
    rsp_tag_q  <= rd_tag_q;
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (rd_v_q) begin
      mem[rd_slot_q] <= cnew;
    end
    rdata_q <= mem[slot_i];
  end

  assign rsp_o  = '{valid: rsp_v_q, cnew: rsp_cnew_q, sat: rsp_sat_q};
  assign tag_o  = rsp_tag_q;
  assign busy_o = busy_q;

endmodule

`default_nettype wire

// File: src/rmsp_out_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Register queue between the pipeline end and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsp_out_fifo #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned W     = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] dout_o
);
  import rmsp_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);

  logic [W-1:0]  buf_q [DEPTH];
  logic [PtrW:0] wptr_q;
  logic [PtrW:0] rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q[PtrW-1:0]] <= din_i;
    end
  end

  assign valid_o = (wptr_q != rptr_q);
  assign dout_o  = buf_q[rptr_q[PtrW-1:0]];

endmodule

`default_nettype wire

// File: dv/tb_rmsprop_weight_update.sv
// ----------------------------------------------------------------------------
// RMSProp weight update testbench
// Drives gradient items and register writes into the block and checks each
// update item against a cycle-free model of the cache and the update math.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rmsprop_weight_update;
  import rmsp_pkg::*;

  // Cycles an item needs from acceptance to the result queue, plus margin.
  localparam int unsigned PipeDrain = 40;

  typedef struct {
    logic [IdxW-1:0]  index;
    logic [DataW-1:0] delta;
    status_e          status;
  } update_t;

  logic clk_i;
  logic rst_ni;

  rmsp_grad_if grad ();
  rmsp_upd_if  upd ();
  rmsp_cfg_if  cfg ();

  rmsprop_weight_update dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .grad_i (grad),
    .upd_o  (upd),
    .cfg_i  (cfg)
  );

  // Model state: cache contents and register copies.
  logic [DataW-1:0]  ms_cache [CacheDepth];
  logic [DataW-1:0]  lr_q;
  logic [DecayW-1:0] decay_q;
  logic [EpsW-1:0]   eps_q;
  logic [BatchW-1:0] batch_q;

  update_t pending_updates[$];
  int      fail_count;
  int      items_sent;
  int      updates_seen;
  int      cfg_writes;
  bit      sender_gaps;
  bit      receiver_stalls;
  int      hold_off_cycles;
  int      stall_left;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // Advance the cache entry and compute the update for one live item.
  function automatic update_t rmsprop_update(logic [IdxW-1:0] index,
                                             logic [DataW-1:0] gradient);
    update_t     u;
    logic        neg;
    logic [63:0] mag, divisor_b, sq, d, c_new, root, div, q;
    logic        sat;
    int unsigned slot;
    neg = gradient[DataW-1];
    mag = neg ? 64'({~gradient + 32'd1}) : 64'(gradient);
    sat = 1'b0;
    divisor_b = (batch_q == '0) ? 64'd1 : 64'(batch_q);
    mag = mag / divisor_b;
    if (mag == 0) neg = 1'b0;
    sq = (mag * mag) >> FracBits;
    if (sq > 64'hFFFF_FFFF) begin
      sq = 64'hFFFF_FFFF;
      sat = 1'b1;
    end
    d = (decay_q > DecayOne) ? 64'(DecayOne) : 64'(decay_q);
    slot = index % CacheDepth;
    c_new = ((64'(ms_cache[slot]) * d) >> FracBits)
          + ((sq * (64'(DecayOne) - d)) >> FracBits);
    if (c_new > 64'hFFFF_FFFF) begin
      c_new = 64'hFFFF_FFFF;
      sat = 1'b1;
    end
    ms_cache[slot] = c_new[DataW-1:0];
    root = int_sqrt(c_new << FracBits);
    div = root + 64'(eps_q);
    u.index = index;
    if (div == 0) begin
      u.delta = '0;
      u.status = StatusDivZero;
      return u;
    end
    q = (mag * 64'(lr_q)) / div;
    if (neg) begin
      if (q > 64'h7FFF_FFFF) begin
        q = 64'h7FFF_FFFF;
        sat = 1'b1;
      end
      u.delta = q[DataW-1:0];
    end else begin
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000;
        sat = 1'b1;
      end
      u.delta = ~q[DataW-1:0] + 32'd1;
    end
    u.status = sat ? StatusSat : StatusOk;
    return u;
  endfunction

  // Offer one gradient item and hold it until accepted; valid stays high.
  task automatic send_grad(logic [IdxW-1:0] index, logic [DataW-1:0] gradient,
                           logic frozen);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      grad.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    grad.valid        <= 1'b1;
    grad.weight_index <= index;
    grad.gradient     <= gradient;
    grad.frozen       <= frozen;
    do @(posedge clk_i); while (!grad.ready);
    items_sent++;
    if (!frozen) pending_updates.push_back(rmsprop_update(index, gradient));
  endtask

  // Stop offering, wait for every owed update, then let the pipe drain.
  task automatic drain_updates();
    grad.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (PipeDrain) @(posedge clk_i);
  endtask

  // Write all four registers back to back; only called while idle.
  task automatic program_regs(logic [DataW-1:0] lr, logic [DataW-1:0] decay,
                              logic [DataW-1:0] eps, logic [DataW-1:0] batch);
    logic [DataW-1:0] vals [4];
    cfg_reg_e         regs [4];
    vals = '{lr, decay, eps, batch};
    regs = '{CfgLearningRate, CfgDecayRate, CfgEpsilon, CfgBatchSize};
    for (int i = 0; i < 4; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= regs[i];
      cfg.data  <= vals[i];
      do @(posedge clk_i); while (!cfg.ready);
      cfg_writes++;
      case (regs[i])
        CfgLearningRate: lr_q    = vals[i];
        CfgDecayRate:    decay_q = vals[i][DecayW-1:0];
        CfgEpsilon:      eps_q   = vals[i][EpsW-1:0];
        default:         batch_q = vals[i][BatchW-1:0];
      endcase
    end
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      upd.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      upd.ready <= 1'b0;
    end else begin
      upd.ready <= 1'b1;
      if (receiver_stalls && $urandom_range(0, 9) < 3) stall_left <= pick_gap();
    end
  end

  // Compare every accepted update with the oldest owed one.
  always @(posedge clk_i) begin
    update_t exp_u;
    if (rst_ni && upd.valid && upd.ready) begin
      updates_seen++;
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected update idx=%0d delta=%h status=%0d", $time,
                 upd.result_index, upd.weight_delta, upd.status);
        fail_count++;
      end else begin
        exp_u = pending_updates.pop_front();
        if (upd.result_index !== exp_u.index) begin
          $display("%0t: result_index expected %0d actual %0d", $time,
                   exp_u.index, upd.result_index);
          fail_count++;
        end
        if (upd.weight_delta !== exp_u.delta) begin
          $display("%0t: weight_delta idx=%0d expected %h actual %h", $time,
                   exp_u.index, exp_u.delta, upd.weight_delta);
          fail_count++;
        end
        if (upd.status !== exp_u.status) begin
          $display("%0t: status idx=%0d expected %0d actual %0d", $time,
                   exp_u.index, exp_u.status, upd.status);
          fail_count++;
        end
      end
    end
  end

  // Field extremes, repeated index, frozen items, reset register values.
  task automatic test_directed_defaults();
    send_grad(12'd0, 32'h0000_0000, 1'b0);
    send_grad(12'd0, 32'h0001_0000, 1'b0);
    send_grad(12'd0, 32'hFFFF_0000, 1'b0);
    send_grad(12'd4095, 32'h7FFF_FFFF, 1'b0);
    send_grad(12'd4095, 32'h8000_0000, 1'b0);
    send_grad(12'd1, 32'h0000_0001, 1'b0);
    send_grad(12'd2, 32'hFFFF_FFFF, 1'b0);
    send_grad(12'd3, 32'h1234_5678, 1'b1);
    send_grad(12'd3, 32'h0002_0000, 1'b0);
    send_grad(12'hAAA, 32'h5555_5555, 1'b0);
    send_grad(12'h555, 32'hAAAA_AAAA, 1'b0);
    drain_updates();
  endtask

  // Register extremes: zero divisor, saturation, decay above one, batch zero.
  task automatic test_directed_extremes();
    // Zero epsilon with a zero gradient on a fresh entry leaves no divisor.
    program_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_grad(12'd100, 32'h0000_0000, 1'b0);
    send_grad(12'd101, 32'h7FFF_FFFF, 1'b0);
    send_grad(12'd102, 32'h8000_0000, 1'b0);
    send_grad(12'd102, 32'h0000_0003, 1'b0);
    drain_updates();
    // Decay above one freezes the cache; large batch shrinks the gradient.
    program_regs(32'h0001_0000, 32'h0001_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    send_grad(12'd101, 32'h7FFF_FFFF, 1'b0);
    send_grad(12'd103, 32'h0000_FFFF, 1'b0);
    send_grad(12'd104, 32'hFFFF_FFFF, 1'b1);
    drain_updates();
    program_regs(32'h0000_8000, 32'h0001_0000, 32'd1, 32'd1);
    send_grad(12'd105, 32'h0010_0000, 1'b0);
    send_grad(12'd105, 32'hFFF0_0000, 1'b0);
    drain_updates();
  endtask

  // Hold the receiver off long enough that the block stalls its input.
  task automatic test_backpressure();
    program_regs(32'd65, 32'd58982, 32'd1, 32'd1);
    sender_gaps = 1'b0;
    hold_off_cycles = 300;
    for (int i = 0; i < 60; i++)
      send_grad(12'($urandom_range(0, 15)), $urandom, 1'b0);
    sender_gaps = 1'b1;
    drain_updates();
  endtask

  // Random phases, each with its own register setting, idle between them.
  task automatic test_random_phases();
    logic [DataW-1:0] g;
    logic [IdxW-1:0]  idx;
    for (int ph = 0; ph < 6; ph++) begin
      program_regs($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 400000),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536),
                   $urandom_range(0, 4) == 0 ? 32'd0 : $urandom_range(0, 65535),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                             : $urandom_range(1, 8));
      receiver_stalls = (ph != 2);
      sender_gaps     = (ph != 3);
      for (int i = 0; i < 65; i++) begin
        idx = ($urandom_range(0, 2) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
        case ($urandom_range(0, 3))
          0:       g = $urandom;
          1:       g = 32'($signed($urandom_range(0, 2000000)) - 1000000);
          2:       g = 32'($signed($urandom_range(0, 1000)) - 500);
          default: g = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
        send_grad(idx, g, $urandom_range(0, 9) == 0);
      end
      drain_updates();
    end
    receiver_stalls = 1'b1;
    sender_gaps = 1'b1;
  endtask

  initial begin
    fail_count      = 0;
    items_sent      = 0;
    updates_seen    = 0;
    cfg_writes      = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_off_cycles = 0;
    stall_left      = 0;
    lr_q    = LrReset;
    decay_q = DecayReset;
    eps_q   = EpsReset;
    batch_q = BatchReset;
    foreach (ms_cache[i]) ms_cache[i] = '0;
    rst_ni            <= 1'b0;
    grad.valid        <= 1'b0;
    grad.weight_index <= '0;
    grad.gradient     <= '0;
    grad.frozen       <= 1'b0;
    cfg.valid         <= 1'b0;
    cfg.index         <= CfgLearningRate;
    cfg.data          <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_defaults();
    test_directed_extremes();
    test_backpressure();
    test_random_phases();

    $display("Covered %0d gradient items, %0d updates checked, %0d register writes,",
             items_sent, updates_seen, cfg_writes);
    $display("including zero divisor, saturation, frozen items and a stalled output.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: rmsprop_weight_update.f
+incdir+src
src/rmsp_pkg.sv
src/rmsp_ifs.sv
src/rmsp_div_pipe.sv
src/rmsp_isqrt_pipe.sv
src/rmsp_cache.sv
src/rmsp_out_fifo.sv
src/rmsprop_weight_update.sv
dv/tb_rmsprop_weight_update.sv
